>>> src/rme_pkg.sv
package rme_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int COUNT_WIDTH  = 16;
  localparam int DIFF_WIDTH   = SAMPLE_WIDTH + 1;
  localparam int BIT_CNT_W    = $clog2(SAMPLE_WIDTH);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [BIT_CNT_W-1:0]   LAST_BIT  = BIT_CNT_W'(SAMPLE_WIDTH - 1);

  typedef logic [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [COUNT_WIDTH-1:0]  count_t;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

endpackage

>>> src/running_mean_estimator.sv
// an ordinary sample passes the divide state and then the finish step; a restart, or
//   the first sample after reset, is loaded and goes straight to the finish step
// the restoring divider by the running count produces one quotient bit per cycle
// input is taken again once the finish step hands over a result, while that still waits
// reset: synchronous active-low rst_n clears estimate, count and all handshake state
module running_mean_estimator (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_restart,
  input  logic signed [rme_pkg::SAMPLE_WIDTH-1:0] in_measurement,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [rme_pkg::SAMPLE_WIDTH-1:0] out_estimate,
  output logic        [rme_pkg::COUNT_WIDTH-1:0]  out_sample_count
);
  import rme_pkg::*;

  logic [1:0]           state_r, state_nxt;
  sample_t              mean_r, mean_nxt;
  count_t               count_r, count_nxt;
  sample_t              quo_r, quo_nxt;
  count_t               rem_r, rem_nxt;
  logic [BIT_CNT_W-1:0] bit_r, bit_nxt;
  logic                 up_r, up_nxt;
  logic                 out_valid_r, out_valid_nxt;
  sample_t              out_est_r, out_est_nxt;
  count_t               out_cnt_r, out_cnt_nxt;

  logic                  in_beat;
  logic                  out_free;
  logic                  sample_ge;
  logic [DIFF_WIDTH-1:0] diff;
  logic [DIFF_WIDTH-1:0] diff_mag;
  count_t                count_inc;
  logic [COUNT_WIDTH:0]  rem_shift;
  logic [COUNT_WIDTH:0]  rem_sub;
  logic                  quo_bit;

  assign in_ready         = (state_r == ST_IDLE);
  assign in_beat          = in_valid && in_ready;
  assign out_free         = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_estimate     = out_est_r;
  assign out_sample_count = out_cnt_r;

  assign sample_ge = ($signed(in_measurement) >= $signed(mean_r));
  assign diff      = {in_measurement[SAMPLE_WIDTH-1], in_measurement}
                   - {mean_r[SAMPLE_WIDTH-1], mean_r};
  assign diff_mag  = sample_ge ? diff : (~diff + DIFF_WIDTH'(1));
  assign count_inc = (count_r == COUNT_MAX) ? count_r : (count_r + COUNT_WIDTH'(1));

  // one restoring step: bring down the next dividend bit, subtract count if it fits
  assign rem_shift = {rem_r, quo_r[SAMPLE_WIDTH-1]};
  assign rem_sub   = rem_shift - {1'b0, count_r};
  assign quo_bit   = !rem_sub[COUNT_WIDTH];

  always_comb begin
    state_nxt     = state_r;
    mean_nxt      = mean_r;
    count_nxt     = count_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    up_nxt        = up_r;
    out_valid_nxt = out_valid_r;
    out_est_nxt   = out_est_r;
    out_cnt_nxt   = out_cnt_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          bit_nxt = '0;
          rem_nxt = '0;
          if (in_restart || (count_r == '0)) begin
            // load directly; the finish step then adds a zero quotient
            mean_nxt  = in_measurement;
            count_nxt = COUNT_WIDTH'(1);
            quo_nxt   = '0;
            up_nxt    = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            count_nxt = count_inc;
            quo_nxt   = diff_mag[SAMPLE_WIDTH-1:0];
            up_nxt    = sample_ge;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = quo_bit ? rem_sub[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
        quo_nxt = {quo_r[SAMPLE_WIDTH-2:0], quo_bit};
        bit_nxt = bit_r + BIT_CNT_W'(1);
        if (bit_r == LAST_BIT) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          mean_nxt      = up_r ? (mean_r + quo_r) : (mean_r - quo_r);
          out_est_nxt   = mean_nxt;
          out_cnt_nxt   = count_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mean_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mean_r      <= mean_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    bit_r     <= bit_nxt;
    up_r      <= up_nxt;
    out_est_r <= out_est_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

endmodule

>>> src/rme_checker.sv
module rme_checker (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    in_restart,
  input logic signed [rme_pkg::SAMPLE_WIDTH-1:0] in_measurement,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [rme_pkg::SAMPLE_WIDTH-1:0] out_estimate,
  input logic        [rme_pkg::COUNT_WIDTH-1:0]  out_sample_count
);
  import rme_pkg::*;

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_estimate)
      && $stable(out_sample_count))
    else $error("result beat changed while stalled");

  // one sample at a time: busy right after an input beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while divider busy");

  // a restart with a free output passes the finish step and comes back loaded
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_restart && !out_valid |=> ##1
      (out_valid && out_sample_count == COUNT_WIDTH'(1)
       && out_estimate == $past(in_measurement, 2)))
    else $error("restart result wrong");

  // every result has averaged at least one sample
  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample_count != '0)
    else $error("result with zero count");

endmodule

bind running_mean_estimator rme_checker u_rme_checker (.*);
